// ===== rtl/bpfa_pkg.sv =====
package bpfa_pkg;

    localparam logic [2:0] OP_INIT      = 3'd0;
    localparam logic [2:0] OP_REQUEST   = 3'd1;
    localparam logic [2:0] OP_FREE      = 3'd2;
    localparam logic [2:0] OP_LOCK      = 3'd3;
    localparam logic [2:0] OP_RESERVE   = 3'd4;
    localparam logic [2:0] OP_UNRESERVE = 3'd5;
    localparam logic [2:0] OP_COUNT     = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PAGE  = 2'd1;
    localparam logic [1:0] ST_INIT_IGN = 2'd2;

    localparam logic [16:0] CNT_MAX = 17'h1FFFF;

    localparam logic REG_MEMORY_PAGES = 1'b0;

    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] first_page;
        logic [16:0] page_count;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_page;
        logic [16:0] free_pages;
        logic [16:0] used_pages;
        logic [16:0] reserved_pages;
        logic [16:0] clear_bit_count;
    } out_t;

endpackage

// ===== rtl/bpfa_bitmap_ram.sv =====
module bpfa_bitmap_ram #(
    parameter int WORDS = 2048,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/bitmap_page_frame_allocator.sv =====
// Page frame allocator over a bitmap of 32-page words held in one memory with one read
// and one write port. Each word is read in S_RD and updated in S_EX: a request scans
// bitmap words from the hint (wrapping once), free, lock, reserve and unreserve walk
// the pages one by one and end on a check in S_RD, a count walks every tracked word,
// and a first init clears every bitmap word in S_CLR. Every operation passes the
// accept in S_IDLE and the result hand-off in S_DONE, which waits on out_stall while a
// result is still held. One operation is in flight at a time; the result register
// lets the next word be taken while a result waits.
module bitmap_page_frame_allocator #(
    parameter int MAX_PAGES = 65536
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bpfa_pkg::in_t in_word,
    output logic          out_valid,
    input  logic          out_stall,
    output bpfa_pkg::out_t out_word,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic          paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int WORDS = (MAX_PAGES + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = (AW + 6 > 18) ? AW + 6 : 18;
    localparam int WW    = PW - 5;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CLR  = 5'b00010,
        S_RD   = 5'b00100,
        S_EX   = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t       state_reg, state_next;
    logic [2:0]   op_reg, op_next;
    logic [PW-1:0] p_reg, p_next;
    logic [16:0]  count_reg, count_next;
    logic [16:0]  idx_reg, idx_next;
    logic [WW-1:0] w_reg, w_next;
    logic [4:0]   lo_reg, lo_next;
    logic         wrap_reg, wrap_next;
    logic [15:0]  hint_reg, hint_next;
    logic [16:0]  free_reg, free_next;
    logic [16:0]  used_reg, used_next;
    logic [16:0]  rsv_reg, rsv_next;
    logic         init_reg, init_next;
    logic [15:0]  mempages_reg;
    logic [1:0]   status_reg, status_next;
    logic [15:0]  granted_reg, granted_next;
    logic [16:0]  clear_reg, clear_next;
    logic         out_valid_reg, out_valid_next;
    bpfa_pkg::out_t out_word_reg, out_word_next;

    logic [PW-1:0] t_raw, t_pages;
    logic [PW-1:0] base;
    logic [PW-1:0] base_nx;
    logic [31:0]  rd_data;
    logic         wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]  wr_data;
    logic [31:0]  mask, cand;
    logic [5:0]   pop;
    logic [4:0]   ff;
    logic         any;
    logic         bit_set;
    logic [31:0]  onehot;
    logic         multi;

    assign pready    = 1'b1;
    assign prdata    = (paddr == bpfa_pkg::REG_MEMORY_PAGES) ? {16'b0, mempages_reg} : 32'b0;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mempages_reg <= 16'b0;
        end
        else if (psel && penable && pwrite && paddr == bpfa_pkg::REG_MEMORY_PAGES)
        begin
            mempages_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        t_raw = PW'({1'b0, mempages_reg[15:3], 3'b0}) + PW'(8);
        if (!init_reg)
        begin
            t_pages = '0;
        end
        else if (t_raw > PW'(MAX_PAGES))
        begin
            t_pages = PW'(MAX_PAGES);
        end
        else
        begin
            t_pages = t_raw;
        end
    end

    assign base    = {w_reg, 5'b0};
    assign base_nx = base + PW'(32);
    assign multi   = (op_reg == bpfa_pkg::OP_FREE) || (op_reg == bpfa_pkg::OP_LOCK) ||
                     (op_reg == bpfa_pkg::OP_RESERVE) || (op_reg == bpfa_pkg::OP_UNRESERVE);
    assign bit_set = rd_data[p_reg[4:0]];
    assign onehot  = 32'b1 << p_reg[4:0];

    always_comb
    begin
        for (int b = 0; b < 32; b++)
        begin
            mask[b] = ((base + PW'(b)) < t_pages) && (5'(b) >= lo_reg);
        end
        cand = ~rd_data & mask;
        any  = |cand;
        ff   = 5'b0;
        for (int b = 31; b >= 0; b--)
        begin
            if (cand[b])
            begin
                ff = 5'(b);
            end
        end
        pop = 6'b0;
        for (int b = 0; b < 32; b++)
        begin
            pop = pop + 6'(cand[b]);
        end
    end

    bpfa_bitmap_ram #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        p_next         = p_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        wrap_next      = wrap_reg;
        hint_next      = hint_reg;
        free_next      = free_reg;
        used_next      = used_reg;
        rsv_next       = rsv_reg;
        init_next      = init_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        clear_next     = clear_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        wr_en          = 1'b0;
        wr_addr        = w_reg[AW-1:0];
        wr_data        = 32'b0;
        rd_en          = 1'b0;
        rd_addr        = multi ? p_reg[AW+4:5] : w_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = in_word.operation;
                    p_next       = PW'(in_word.first_page);
                    count_next   = in_word.page_count;
                    idx_next     = 17'b0;
                    status_next  = bpfa_pkg::ST_OK;
                    granted_next = 16'b0;
                    clear_next   = 17'b0;
                    w_next       = '0;
                    lo_next      = 5'b0;
                    wrap_next    = 1'b0;
                    state_next   = S_DONE;
                    case (in_word.operation)
                        bpfa_pkg::OP_INIT:
                        begin
                            if (init_reg)
                            begin
                                status_next = bpfa_pkg::ST_INIT_IGN;
                            end
                            else
                            begin
                                state_next = S_CLR;
                            end
                        end
                        bpfa_pkg::OP_REQUEST:
                        begin
                            if (t_pages == '0)
                            begin
                                status_next = bpfa_pkg::ST_NO_PAGE;
                                hint_next   = 16'b0;
                            end
                            else
                            begin
                                state_next = S_RD;
                                if (PW'(hint_reg) < t_pages)
                                begin
                                    w_next  = WW'(hint_reg[15:5]);
                                    lo_next = hint_reg[4:0];
                                end
                                else
                                begin
                                    wrap_next = 1'b1;
                                end
                            end
                        end
                        bpfa_pkg::OP_FREE, bpfa_pkg::OP_LOCK,
                        bpfa_pkg::OP_RESERVE, bpfa_pkg::OP_UNRESERVE:
                        begin
                            state_next = S_RD;
                        end
                        bpfa_pkg::OP_COUNT:
                        begin
                            if (t_pages != '0)
                            begin
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_CLR:
            begin
                wr_en   = 1'b1;
                wr_addr = w_reg[AW-1:0];
                wr_data = 32'b0;
                w_next  = w_reg + WW'(1);
                if (w_reg == WW'(WORDS - 1))
                begin
                    init_next  = 1'b1;
                    hint_next  = 16'b0;
                    free_next  = {1'b0, mempages_reg};
                    used_next  = 17'b0;
                    rsv_next   = 17'b0;
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                if (multi && (idx_reg == count_reg || p_reg >= t_pages))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_EX;
                end
            end
            S_EX:
            begin
                state_next = S_RD;
                if (multi)
                begin
                    wr_addr  = p_reg[AW+4:5];
                    wr_data  = rd_data ^ onehot;
                    p_next   = p_reg + PW'(1);
                    idx_next = idx_reg + 17'd1;
                    if ((op_reg == bpfa_pkg::OP_LOCK || op_reg == bpfa_pkg::OP_RESERVE)
                        && !bit_set)
                    begin
                        wr_en = 1'b1;
                        if (free_reg != 17'b0)
                        begin
                            free_next = free_reg - 17'd1;
                        end
                        if (op_reg == bpfa_pkg::OP_LOCK)
                        begin
                            if (used_reg != bpfa_pkg::CNT_MAX)
                            begin
                                used_next = used_reg + 17'd1;
                            end
                        end
                        else if (rsv_reg != bpfa_pkg::CNT_MAX)
                        begin
                            rsv_next = rsv_reg + 17'd1;
                        end
                    end
                    if ((op_reg == bpfa_pkg::OP_FREE || op_reg == bpfa_pkg::OP_UNRESERVE)
                        && bit_set)
                    begin
                        wr_en = 1'b1;
                        if (PW'(hint_reg) > p_reg)
                        begin
                            hint_next = p_reg[15:0];
                        end
                        if (free_reg != bpfa_pkg::CNT_MAX)
                        begin
                            free_next = free_reg + 17'd1;
                        end
                        if (op_reg == bpfa_pkg::OP_FREE)
                        begin
                            if (used_reg != 17'b0)
                            begin
                                used_next = used_reg - 17'd1;
                            end
                        end
                        else if (rsv_reg != 17'b0)
                        begin
                            rsv_next = rsv_reg - 17'd1;
                        end
                    end
                end
                else if (op_reg == bpfa_pkg::OP_COUNT)
                begin
                    clear_next = clear_reg + 17'(pop);
                    w_next     = w_reg + WW'(1);
                    if (base_nx >= t_pages)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    lo_next = 5'b0;
                    if (any)
                    begin
                        wr_en        = 1'b1;
                        wr_addr      = w_reg[AW-1:0];
                        wr_data      = rd_data | (32'b1 << ff);
                        granted_next = 16'(base + PW'(ff));
                        hint_next    = 16'(base + PW'(ff));
                        if (free_reg != 17'b0)
                        begin
                            free_next = free_reg - 17'd1;
                        end
                        if (used_reg != bpfa_pkg::CNT_MAX)
                        begin
                            used_next = used_reg + 17'd1;
                        end
                        state_next = S_DONE;
                    end
                    else if (base_nx >= t_pages)
                    begin
                        if (!wrap_reg)
                        begin
                            wrap_next = 1'b1;
                            w_next    = '0;
                        end
                        else
                        begin
                            status_next = bpfa_pkg::ST_NO_PAGE;
                            hint_next   = 16'b0;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        w_next = w_reg + WW'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next.status          = status_reg;
                    out_word_next.granted_page    = granted_reg;
                    out_word_next.free_pages      = free_reg;
                    out_word_next.used_pages      = used_reg;
                    out_word_next.reserved_pages  = rsv_reg;
                    out_word_next.clear_bit_count = clear_reg;
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hint_reg      <= 16'b0;
            free_reg      <= 17'b0;
            used_reg      <= 17'b0;
            rsv_reg       <= 17'b0;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            free_reg      <= free_next;
            used_reg      <= used_next;
            rsv_reg       <= rsv_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        p_reg        <= p_next;
        count_reg    <= count_next;
        idx_reg      <= idx_next;
        w_reg        <= w_next;
        lo_reg       <= lo_next;
        wrap_reg     <= wrap_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
        clear_reg    <= clear_next;
        out_word_reg <= out_word_next;
    end

endmodule

// ===== sim/bpfa_checker.sv =====
module bpfa_checker #(
    parameter int MAX_PAGES = 65536
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_stall,
    input  bpfa_pkg::in_t  in_word,
    input  logic out_valid,
    input  logic out_stall,
    input  bpfa_pkg::out_t out_word,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic paddr,
    input  logic [31:0] pwdata,
    input  logic pready,
    output int   mismatches,
    output int   pending,
    output int   results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    bit          frame_taken [MAX_PAGES];
    int unsigned scan_hint;
    int unsigned free_cnt;
    int unsigned used_cnt;
    int unsigned rsv_cnt;
    bit          alloc_ready;
    int unsigned mem_pages;
    bpfa_pkg::out_t expected_words [$];

    function automatic int unsigned tracked_span();
        int unsigned t;
        if (!alloc_ready)
            return 0;
        t = (mem_pages / 8) * 8 + 8;
        return (t > MAX_PAGES) ? MAX_PAGES : t;
    endfunction

    function automatic int unsigned sat_up(int unsigned c);
        return (c < bpfa_pkg::CNT_MAX) ? c + 1 : c;
    endfunction

    function automatic int unsigned sat_down(int unsigned c);
        return (c > 0) ? c - 1 : c;
    endfunction

    task automatic take_frame(int unsigned p, bit to_reserved);
        if (frame_taken[p])
            return;
        frame_taken[p] = 1;
        free_cnt = sat_down(free_cnt);
        if (to_reserved)
            rsv_cnt = sat_up(rsv_cnt);
        else
            used_cnt = sat_up(used_cnt);
    endtask

    task automatic return_frame(int unsigned p, bit from_reserved);
        if (!frame_taken[p])
            return;
        frame_taken[p] = 0;
        if (scan_hint > p)
            scan_hint = p;
        free_cnt = sat_up(free_cnt);
        if (from_reserved)
            rsv_cnt = sat_down(rsv_cnt);
        else
            used_cnt = sat_down(used_cnt);
    endtask

    task automatic allocate_word(input bpfa_pkg::in_t w, output bpfa_pkg::out_t r);
        int unsigned t;
        int unsigned p;
        int unsigned clear_bits;
        bit found;
        t = tracked_span();
        r = '0;
        clear_bits = 0;
        case (w.operation)
            bpfa_pkg::OP_INIT:
            begin
                if (alloc_ready)
                    r.status = bpfa_pkg::ST_INIT_IGN;
                else
                begin
                    alloc_ready = 1;
                    foreach (frame_taken[i])
                        frame_taken[i] = 0;
                    scan_hint = 0;
                    free_cnt = mem_pages;
                    used_cnt = 0;
                    rsv_cnt = 0;
                end
            end
            bpfa_pkg::OP_REQUEST:
            begin
                found = 0;
                for (p = scan_hint; p < t; p++)
                    if (!frame_taken[p])
                    begin
                        found = 1;
                        break;
                    end
                if (!found)
                    for (p = 0; p < t; p++)
                        if (!frame_taken[p])
                        begin
                            found = 1;
                            break;
                        end
                if (found)
                begin
                    scan_hint = p;
                    take_frame(p, 0);
                    r.granted_page = p[15:0];
                end
                else
                begin
                    scan_hint = 0;
                    r.status = bpfa_pkg::ST_NO_PAGE;
                end
            end
            bpfa_pkg::OP_FREE, bpfa_pkg::OP_LOCK, bpfa_pkg::OP_RESERVE,
            bpfa_pkg::OP_UNRESERVE:
            begin
                for (int unsigned i = 0; i < w.page_count; i++)
                begin
                    p = w.first_page + i;
                    if (p >= t)
                        break;
                    case (w.operation)
                        bpfa_pkg::OP_FREE:    return_frame(p, 0);
                        bpfa_pkg::OP_LOCK:    take_frame(p, 0);
                        bpfa_pkg::OP_RESERVE: take_frame(p, 1);
                        default:              return_frame(p, 1);
                    endcase
                end
            end
            bpfa_pkg::OP_COUNT:
            begin
                for (p = 0; p < t; p++)
                    if (!frame_taken[p])
                        clear_bits++;
            end
            default: ;
        endcase
        r.free_pages = free_cnt[16:0];
        r.used_pages = used_cnt[16:0];
        r.reserved_pages = rsv_cnt[16:0];
        r.clear_bit_count = clear_bits[16:0];
    endtask

    always @(posedge clk)
    begin
        bpfa_pkg::out_t e;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == bpfa_pkg::REG_MEMORY_PAGES)
                mem_pages = pwdata[15:0];
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t unexpected word %p", $realtime, out_word);
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (e.status !== out_word.status
                        || e.granted_page !== out_word.granted_page
                        || e.free_pages !== out_word.free_pages
                        || e.used_pages !== out_word.used_pages
                        || e.reserved_pages !== out_word.reserved_pages
                        || e.clear_bit_count !== out_word.clear_bit_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%t mismatch exp %p act %p", $realtime, e, out_word);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                allocate_word(in_word, e);
                expected_words.push_back(e);
            end
            pending = expected_words.size();
        end
    end
endmodule

// ===== sim/tb_bitmap_page_frame_allocator.sv =====
module tb_bitmap_page_frame_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    bpfa_pkg::in_t  in_word = '0;
    logic        out_valid;
    logic        out_stall = 0;
    bpfa_pkg::out_t out_word;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic        paddr = bpfa_pkg::REG_MEMORY_PAGES;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int results_seen;
    int words_sent = 0;
    int hold_left = 0;
    bit hold_go = 0;
    bit no_gaps = 0;
    int mem_pages = 0;

    always #2 clk = ~clk;

    bitmap_page_frame_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bpfa_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .pending(pending), .results_seen(results_seen)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_word(logic [2:0] op, int first, int cnt);
        int gap;
        @(negedge clk);
        in_valid <= 1;
        in_word <= '{operation: op, first_page: first[15:0], page_count: cnt[16:0]};
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_mem_pages(int value);
        drain();
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= bpfa_pkg::REG_MEMORY_PAGES;
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        mem_pages = value;
    endtask

    task automatic send_random(int n);
        int span;
        int r;
        logic [2:0] op;
        int first;
        int cnt;
        bit wide;
        span = (mem_pages / 8) * 8 + 8;
        wide = span > 4096;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                op = bpfa_pkg::OP_REQUEST;
            else if (r < 45)
                op = bpfa_pkg::OP_FREE;
            else if (r < 57)
                op = bpfa_pkg::OP_LOCK;
            else if (r < 69)
                op = bpfa_pkg::OP_RESERVE;
            else if (r < 81)
                op = bpfa_pkg::OP_UNRESERVE;
            else if (r < 95)
                op = (wide && r > 82) ? bpfa_pkg::OP_REQUEST : bpfa_pkg::OP_COUNT;
            else if (r < 98)
                op = bpfa_pkg::OP_INIT;
            else
                op = OP_UNUSED;
            first = ($urandom_range(0, 4) != 0) ? $urandom_range(0, span - 1) : $urandom;
            if ($urandom_range(0, 6) != 0)
                cnt = $urandom_range(0, (span < 16) ? span : 16);
            else
                cnt = $urandom_range(0, wide ? 64 : span + 8);
            send_word(op, first & 16'hFFFF, cnt);
        end
    endtask

    always @(negedge clk)
    begin
        int run;
        bit level;
        bit hold_taken;
        if (hold_go && !hold_taken)
        begin
            hold_taken = 1;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1;
            hold_left--;
        end
        else if (run > 0)
        begin
            out_stall <= level;
            run--;
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4:
                begin
                    level = 0;
                    run = $urandom_range(1, 8);
                end
                5, 6, 7:
                begin
                    level = 1;
                    run = $urandom_range(1, 3);
                end
                8:
                begin
                    level = 1;
                    run = $urandom_range(20, 60);
                end
                default:
                begin
                    level = 0;
                    run = $urandom_range(50, 200);
                end
            endcase
            out_stall <= level;
        end
    end

    initial
    begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // before init the range is empty
        send_word(bpfa_pkg::OP_REQUEST, 0, 0);
        send_word(bpfa_pkg::OP_LOCK, 0, 5);
        send_word(bpfa_pkg::OP_COUNT, 0, 0);
        send_word(bpfa_pkg::OP_FREE, 0, 5);
        send_word(OP_UNUSED, 16'hFFFF, 17'h1FFFF & 65536);

        write_mem_pages(40);
        send_word(bpfa_pkg::OP_INIT, 0, 0);
        send_word(bpfa_pkg::OP_INIT, 0, 0);
        send_word(bpfa_pkg::OP_REQUEST, 0, 0);
        send_word(bpfa_pkg::OP_REQUEST, 0, 0);
        send_word(bpfa_pkg::OP_RESERVE, 10, 4);
        send_word(bpfa_pkg::OP_UNRESERVE, 11, 1);
        send_word(bpfa_pkg::OP_FREE, 0, 1);
        send_word(bpfa_pkg::OP_LOCK, 65535, 1);
        send_word(bpfa_pkg::OP_LOCK, 0, 65535);
        send_word(bpfa_pkg::OP_REQUEST, 0, 0);
        send_word(bpfa_pkg::OP_COUNT, 0, 0);
        send_word(bpfa_pkg::OP_FREE, 0, 65536);
        send_word(bpfa_pkg::OP_RESERVE, 0, 48);
        send_word(bpfa_pkg::OP_REQUEST, 0, 0);
        send_word(bpfa_pkg::OP_UNRESERVE, 5, 0);
        send_word(bpfa_pkg::OP_UNRESERVE, 40, 3);
        send_word(bpfa_pkg::OP_REQUEST, 0, 0);
        send_word(bpfa_pkg::OP_COUNT, 0, 0);

        send_random(120);
        hold_go = 1;
        no_gaps = 1;
        send_random(40);
        no_gaps = 0;
        drain();
        send_random(90);

        write_mem_pages(0);
        send_random(100);

        write_mem_pages(65528);
        send_random(50);

        repeat (3)
        begin
            write_mem_pages($urandom_range(0, 300));
            no_gaps = $urandom_range(0, 1);
            send_random(110);
        end
        no_gaps = 0;

        drain();
        repeat (50) @(posedge clk);
        $display("sent %0d words, checked %0d results over six page-count settings",
                 words_sent, results_seen);
        $display("all ops, uninitialized and repeated init, range edges, counter floors");
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
